// ===== hw/rtl/d8lq_pkg.sv =====
package d8lq_pkg;

    localparam int NDIM            = 8;
    localparam int IDX_W           = $clog2(NDIM);
    localparam int OUT_W           = 9;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

endpackage

// ===== hw/rtl/d8_lattice_quantizer_top.sv =====
// channel | ports                       | direction | request moves
// --------+-----------------------------+-----------+------------------------------
// s_      | s_valid s_ready s_coord_0..7 | in        | one 8-dim fixed-point point
// m_      | m_valid m_ready m_lattice_0..7 | out     | nearest D8 lattice point
//
// Four register stages: round each coordinate, reduce 8->4 errors, reduce 4->1,
// apply the parity step. One request per cycle is sustained while m_ready stays high.
// aresetn (synchronous, active low) clears the stage valid bits only.
// A stall at m_ready holds the output; each stage keeps moving while the stage
// after it has room, so bubbles are filled and nothing is dropped or repeated.
module d8_lattice_quantizer_top #(
    parameter int COORD_WIDTH = d8lq_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = d8lq_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_coord_0,
    input  logic signed [COORD_WIDTH-1:0]        s_coord_1,
    input  logic signed [COORD_WIDTH-1:0]        s_coord_2,
    input  logic signed [COORD_WIDTH-1:0]        s_coord_3,
    input  logic signed [COORD_WIDTH-1:0]        s_coord_4,
    input  logic signed [COORD_WIDTH-1:0]        s_coord_5,
    input  logic signed [COORD_WIDTH-1:0]        s_coord_6,
    input  logic signed [COORD_WIDTH-1:0]        s_coord_7,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [d8lq_pkg::OUT_W-1:0]    m_lattice_0,
    output logic signed [d8lq_pkg::OUT_W-1:0]    m_lattice_1,
    output logic signed [d8lq_pkg::OUT_W-1:0]    m_lattice_2,
    output logic signed [d8lq_pkg::OUT_W-1:0]    m_lattice_3,
    output logic signed [d8lq_pkg::OUT_W-1:0]    m_lattice_4,
    output logic signed [d8lq_pkg::OUT_W-1:0]    m_lattice_5,
    output logic signed [d8lq_pkg::OUT_W-1:0]    m_lattice_6,
    output logic signed [d8lq_pkg::OUT_W-1:0]    m_lattice_7
);
    import d8lq_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int AW  = (W > F ? W : F) + 1;
    localparam int MW  = AW - F + 1;
    localparam int ZW  = MW + 1;
    localparam int XW  = (ZW > OUT_W) ? ZW : OUT_W;
    localparam int HALF = NDIM / 2;

    logic signed [W-1:0] cin [NDIM];

    assign cin[0] = s_coord_0;
    assign cin[1] = s_coord_1;
    assign cin[2] = s_coord_2;
    assign cin[3] = s_coord_3;
    assign cin[4] = s_coord_4;
    assign cin[5] = s_coord_5;
    assign cin[6] = s_coord_6;
    assign cin[7] = s_coord_7;

    logic rdy1, rdy2, rdy3, rdy4;

    logic               v1_reg;
    logic signed [ZW-1:0] z1_reg  [NDIM];
    logic signed [ZW-1:0] z1_next [NDIM];
    logic [F-1:0]       ae1_reg  [NDIM];
    logic [F-1:0]       ae1_next [NDIM];
    logic [NDIM-1:0]    ep1_reg, ep1_next;

    logic               v2_reg;
    logic signed [ZW-1:0] z2_reg [NDIM];
    logic [F-1:0]       ae2_reg  [HALF];
    logic [F-1:0]       ae2_next [HALF];
    logic [IDX_W-1:0]   ix2_reg  [HALF];
    logic [IDX_W-1:0]   ix2_next [HALF];
    logic [HALF-1:0]    ep2_reg, ep2_next;
    logic               par2_reg, par2_next;

    logic               v3_reg;
    logic signed [ZW-1:0] z3_reg [NDIM];
    logic [IDX_W-1:0]   ix3_reg, ix3_next;
    logic               ep3_reg, ep3_next;
    logic               par3_reg;

    logic               v4_reg;
    logic signed [OUT_W-1:0] out_reg  [NDIM];
    logic signed [OUT_W-1:0] out_next [NDIM];

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // round half away from zero, error magnitude and sign from the fraction bits
    always_comb begin
        logic          c_neg;
        logic [AW-1:0] ext;
        logic [AW-1:0] a;
        logic [F-1:0]  r;
        logic [MW-1:0] mag;
        logic signed [ZW-1:0] zp;
        for (int i = 0; i < NDIM; i++) begin
            c_neg = cin[i][W-1];
            ext   = AW'(cin[i]);
            a     = c_neg ? (~ext + AW'(1)) : ext;
            r     = a[F-1:0];
            mag   = MW'(a >> F) + MW'(r[F-1]);
            zp    = $signed(ZW'(mag));
            z1_next[i]  = c_neg ? -zp : zp;
            ae1_next[i] = r[F-1] ? (~r + F'(1)) : r;
            ep1_next[i] = c_neg ? r[F-1] : (!r[F-1] && (r != '0));
        end
    end

    // first reduction level, ties keep the lower index
    always_comb begin
        logic p;
        p = 1'b0;
        for (int j = 0; j < HALF; j++) begin
            if (ae1_reg[2*j+1] > ae1_reg[2*j]) begin
                ae2_next[j] = ae1_reg[2*j+1];
                ix2_next[j] = IDX_W'(2*j+1);
                ep2_next[j] = ep1_reg[2*j+1];
            end else begin
                ae2_next[j] = ae1_reg[2*j];
                ix2_next[j] = IDX_W'(2*j);
                ep2_next[j] = ep1_reg[2*j];
            end
        end
        for (int i = 0; i < NDIM; i++) begin
            p = p ^ z1_reg[i][0];
        end
        par2_next = p;
    end

    always_comb begin
        logic [F-1:0]     ae_a, ae_b;
        logic [IDX_W-1:0] ix_a, ix_b;
        logic             ep_a, ep_b;
        if (ae2_reg[1] > ae2_reg[0]) begin
            ae_a = ae2_reg[1]; ix_a = ix2_reg[1]; ep_a = ep2_reg[1];
        end else begin
            ae_a = ae2_reg[0]; ix_a = ix2_reg[0]; ep_a = ep2_reg[0];
        end
        if (ae2_reg[3] > ae2_reg[2]) begin
            ae_b = ae2_reg[3]; ix_b = ix2_reg[3]; ep_b = ep2_reg[3];
        end else begin
            ae_b = ae2_reg[2]; ix_b = ix2_reg[2]; ep_b = ep2_reg[2];
        end
        if (ae_b > ae_a) begin
            ix3_next = ix_b;
            ep3_next = ep_b;
        end else begin
            ix3_next = ix_a;
            ep3_next = ep_a;
        end
    end

    // step the chosen coordinate toward its input when the sum is odd
    always_comb begin
        logic signed [ZW-1:0] zadj;
        logic signed [XW-1:0] zx;
        for (int i = 0; i < NDIM; i++) begin
            zadj = z3_reg[i];
            if (par3_reg && (ix3_reg == IDX_W'(i))) begin
                zadj = ep3_reg ? (z3_reg[i] + ZW'(1)) : (z3_reg[i] - ZW'(1));
            end
            zx = XW'(zadj);
            out_next[i] = zx[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            z1_reg  <= z1_next;
            ae1_reg <= ae1_next;
            ep1_reg <= ep1_next;
        end
        if (rdy2 && v1_reg) begin
            z2_reg   <= z1_reg;
            ae2_reg  <= ae2_next;
            ix2_reg  <= ix2_next;
            ep2_reg  <= ep2_next;
            par2_reg <= par2_next;
        end
        if (rdy3 && v2_reg) begin
            z3_reg   <= z2_reg;
            ix3_reg  <= ix3_next;
            ep3_reg  <= ep3_next;
            par3_reg <= par2_reg;
        end
        if (rdy4 && v3_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid     = v4_reg;
    assign m_lattice_0 = out_reg[0];
    assign m_lattice_1 = out_reg[1];
    assign m_lattice_2 = out_reg[2];
    assign m_lattice_3 = out_reg[3];
    assign m_lattice_4 = out_reg[4];
    assign m_lattice_5 = out_reg[5];
    assign m_lattice_6 = out_reg[6];
    assign m_lattice_7 = out_reg[7];

    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("pipeline stalls while output is taken");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("output valid right after reset");

    a_even_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_lattice_0[0] ^ m_lattice_1[0] ^ m_lattice_2[0] ^ m_lattice_3[0]
                      ^ m_lattice_4[0] ^ m_lattice_5[0] ^ m_lattice_6[0] ^ m_lattice_7[0]))
        else $error("result has odd coordinate sum");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("request lost in pipeline");

endmodule

// ===== verif/d8_lattice_quantizer_top_test.sv =====
`timescale 1ns / 100ps

module d8_lattice_quantizer_top_test;

    localparam int NDIM       = d8lq_pkg::NDIM;
    localparam int OUT_W      = d8lq_pkg::OUT_W;
    localparam int COORD_W    = d8lq_pkg::COORD_WIDTH_DEF;
    localparam int FRAC       = d8lq_pkg::FRAC_BITS_DEF;
    localparam int TABLE_ROWS = 18;
    localparam int HOLD_LEN   = 120;
    localparam int CYCLE_CAP  = 200000;

    typedef logic [NDIM-1:0][COORD_W-1:0] point_t;
    typedef logic [NDIM-1:0][OUT_W-1:0]   lattice_t;

    typedef struct packed {
        point_t   pt;
        logic     typed;
        lattice_t want;
    } point_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    point_t   s_point = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    wire  [NDIM-1:0][OUT_W-1:0] m_point;

    lattice_t   pending_lattice [$];
    point_row_t directed_rows [TABLE_ROWS];
    int         idle_pct   = 0;
    int         stall_pct  = 0;
    logic       hold_req   = 1'b0;
    logic       hold_done  = 1'b0;
    int         hold_left  = 0;
    int         fail_count = 0;
    int         cycle_count = 0;

    d8_lattice_quantizer_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_coord_0   (s_point[0]),
        .s_coord_1   (s_point[1]),
        .s_coord_2   (s_point[2]),
        .s_coord_3   (s_point[3]),
        .s_coord_4   (s_point[4]),
        .s_coord_5   (s_point[5]),
        .s_coord_6   (s_point[6]),
        .s_coord_7   (s_point[7]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_lattice_0 (m_point[0]),
        .m_lattice_1 (m_point[1]),
        .m_lattice_2 (m_point[2]),
        .m_lattice_3 (m_point[3]),
        .m_lattice_4 (m_point[4]),
        .m_lattice_5 (m_point[5]),
        .m_lattice_6 (m_point[6]),
        .m_lattice_7 (m_point[7])
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic point_t pt(input int a0, a1, a2, a3, a4, a5, a6, a7);
        point_t r;
        r[0] = a0[COORD_W-1:0];
        r[1] = a1[COORD_W-1:0];
        r[2] = a2[COORD_W-1:0];
        r[3] = a3[COORD_W-1:0];
        r[4] = a4[COORD_W-1:0];
        r[5] = a5[COORD_W-1:0];
        r[6] = a6[COORD_W-1:0];
        r[7] = a7[COORD_W-1:0];
        return r;
    endfunction

    function automatic lattice_t lt(input int a0, a1, a2, a3, a4, a5, a6, a7);
        lattice_t r;
        r[0] = a0[OUT_W-1:0];
        r[1] = a1[OUT_W-1:0];
        r[2] = a2[OUT_W-1:0];
        r[3] = a3[OUT_W-1:0];
        r[4] = a4[OUT_W-1:0];
        r[5] = a5[OUT_W-1:0];
        r[6] = a6[OUT_W-1:0];
        r[7] = a7[OUT_W-1:0];
        return r;
    endfunction

    function automatic lattice_t nearest_d8(input point_t p);
        longint   z [NDIM];
        longint   err [NDIM];
        longint   c;
        longint   mag;
        longint   abs_err;
        longint   best;
        longint   total;
        longint   tmp;
        int       pick;
        int       i;
        lattice_t r;
        best  = -1;
        pick  = 0;
        total = 0;
        for (i = 0; i < NDIM; i++) begin
            c   = $signed(p[i]);
            mag = ((c < 0 ? -c : c) + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            z[i]   = (c < 0) ? -mag : mag;
            err[i] = c - z[i] * (64'sd1 <<< FRAC);
            abs_err = (err[i] < 0) ? -err[i] : err[i];
            if (abs_err > best) begin
                best = abs_err;
                pick = i;
            end
            total += z[i];
        end
        if (total[0])
            z[pick] += (err[pick] > 0) ? 1 : -1;
        for (i = 0; i < NDIM; i++) begin
            tmp  = z[i];
            r[i] = tmp[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord(input bit whole);
        int v;
        int k;
        k = $urandom_range(254);
        k = k - 127;
        if (whole)
            v = k * (1 << FRAC);
        else begin
            case ($urandom_range(4))
                0: v = $urandom;
                1: begin
                    v = $urandom_range(4);
                    v = k * (1 << FRAC) + (1 << (FRAC - 1)) + v - 2;
                end
                2: begin
                    v = $urandom_range(2048);
                    v = v - 1024;
                end
                3: v = k * (1 << FRAC);
                default: begin
                    v = $urandom_range(3);
                    v = $urandom_range(1) ? 32767 - v : -32768 + v;
                end
            endcase
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic point_t random_point();
        point_t r;
        bit     whole;
        int     i;
        whole = ($urandom_range(7) == 0);
        for (i = 0; i < NDIM; i++)
            r[i] = random_coord(whole);
        return r;
    endfunction

    task automatic offer(input point_t p, input logic typed, input lattice_t want);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_point <= p;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_lattice.push_back(typed ? want : nearest_d8(p));
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        idle_pct = idle;
        stall_pct <= stall;
        repeat (count)
            offer(random_point(), 1'b0, '0);
    endtask

    always @(posedge aclk) begin : result_side
        lattice_t want;
        int       k;
        if (m_valid === 1'b1 && m_ready) begin
            if (pending_lattice.size() == 0) begin
                $error("lattice result with no point pending");
                fail_count++;
            end else begin
                want = pending_lattice.pop_front();
                for (k = 0; k < NDIM; k++) begin
                    if (m_point[k] !== want[k]) begin
                        $error("lattice_%0d: expected %0d, got %0d", k,
                               $signed(want[k]), $signed(m_point[k]));
                        fail_count++;
                    end
                end
            end
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int r;
        directed_rows = '{
            '{pt(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, lt(0, 0, 0, 0, 0, 0, 0, 0)},
            '{pt(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b1,
              lt(128, 128, 128, 128, 128, 128, 128, 128)},
            '{pt(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 1'b1,
              lt(-128, -128, -128, -128, -128, -128, -128, -128)},
            '{pt(256, 0, 0, 0, 0, 0, 0, 0), 1'b1, lt(0, 0, 0, 0, 0, 0, 0, 0)},
            '{pt(-32768, 256, 0, 0, 0, 0, 0, 0), 1'b1, lt(-129, 1, 0, 0, 0, 0, 0, 0)},
            '{pt(32767, 256, 0, 0, 0, 0, 0, 0), 1'b1, lt(127, 1, 0, 0, 0, 0, 0, 0)},
            '{pt(-256, 0, 0, 0, 0, 0, 0, 0), 1'b1, lt(-2, 0, 0, 0, 0, 0, 0, 0)},
            '{pt(128, 128, 128, 128, 128, 128, 128, 128), 1'b0, '0},
            '{pt(-128, -128, -128, -128, -128, -128, -128, -128), 1'b0, '0},
            '{pt(128, 128, 128, 0, 0, 0, 0, 0), 1'b0, '0},
            '{pt(0, 0, 0, 0, 0, 0, 0, -128), 1'b0, '0},
            '{pt(127, -127, 129, -129, 383, -383, 385, -385), 1'b0, '0},
            '{pt(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0},
            '{pt(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768), 1'b0, '0},
            '{pt(21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846), 1'b0, '0},
            '{pt(-21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845), 1'b0, '0},
            '{pt(64, 64, 64, 64, 64, 64, 64, 96), 1'b0, '0},
            '{pt(0, 0, 0, 0, 0, 0, 0, 383), 1'b0, '0}
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_pct = 36;
        stall_pct <= 36;
        for (r = 0; r < TABLE_ROWS; r++)
            offer(directed_rows[r].pt, directed_rows[r].typed, directed_rows[r].want);

        run_random(300, 0, 0);
        run_random(300, 67, 0);
        run_random(300, 0, 67);
        run_random(300, 36, 36);
        // back up the pipeline while requests keep coming
        hold_req <= 1'b1;
        run_random(150, 0, 0);
        run_random(200, 50, 50);

        s_valid <= 1'b0;
        stall_pct <= 0;
        while (pending_lattice.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
